FILE: rtl/rsa_pkg.sv
// Shared types and constants for the rumble source arbiter.
// Used by rsa_step and rumble_source_arbiter_core; no dependencies.
`timescale 1ns / 1ps

package rsa_pkg;

  // Field widths
  localparam int unsigned TimeWidth     = 62;
  localparam int unsigned HoldWidth     = 32;
  localparam int unsigned DeadlineWidth = 63;
  localparam int unsigned ScaledWidth   = 42;  // hold (32 bits) times 1000 (10 bits)
  localparam int unsigned BurstWidth    = 8;
  localparam int unsigned CntWidth      = 32;  // event counters wrap here
  localparam int unsigned OutCntWidth   = 32;  // reported counter bits

  localparam logic [9:0]  UsPerMs       = 10'd1000;
  localparam logic [BurstWidth-1:0] BurstReset = 8'd3;

  // Event counter slots
  localparam int unsigned EvSwitch   = 0;
  localparam int unsigned EvPreempt  = 1;
  localparam int unsigned EvFallback = 2;
  localparam int unsigned EvBlocked  = 3;
  localparam int unsigned EvModeChg  = 4;
  localparam int unsigned EvCompat   = 5;
  localparam int unsigned EvHaptic   = 6;
  localparam int unsigned EvCount    = 7;

  // Register byte addresses
  localparam logic [2:0] AddrStopBurst = 3'd0;

  typedef enum logic [1:0] {
    CmdSetMode = 2'd0,
    CmdUpdOrd  = 2'd1,
    CmdUpdHd   = 2'd2,
    CmdTick    = 2'd3
  } rsa_cmd_e;

  typedef enum logic [1:0] {
    SrcNone = 2'd0,
    SrcOrd  = 2'd1,
    SrcHd   = 2'd2
  } rsa_src_e;

  typedef enum logic {
    ModeHaptic = 1'b0,
    ModeCompat = 1'b1
  } rsa_mode_e;

  typedef struct packed {
    rsa_cmd_e               cmd;
    logic                   mode_req;
    logic                   src_active;
    logic [TimeWidth-1:0]   now_us;
    logic [HoldWidth-1:0]   hold_ms;
  } rsa_item_t;

  typedef struct packed {
    rsa_mode_e                          mode;
    logic                               ord_on;
    logic [DeadlineWidth-1:0]           ord_deadline;
    logic                               hd_on;
    logic [DeadlineWidth-1:0]           hd_deadline;
    rsa_src_e                           sel;
    logic [BurstWidth-1:0]              stops_left;
    logic [EvCount-1:0][CntWidth-1:0]   counters;
  } rsa_state_t;

  typedef struct packed {
    rsa_src_e                           chosen;
    rsa_src_e                           earlier;
    logic                               switched;
    logic                               emit_stop;
    rsa_mode_e                          mode;
    logic [EvCount-1:0][OutCntWidth-1:0] counters;
  } rsa_result_t;

endpackage

FILE: rtl/rsa_step.sv
// Next-state and result logic for one command of the rumble source arbiter.
// Purely combinational; depends on rsa_pkg.
`timescale 1ns / 1ps

module rsa_step (
  input  rsa_pkg::rsa_item_t                   item_i,
  input  rsa_pkg::rsa_state_t                  state_i,
  input  logic [rsa_pkg::BurstWidth-1:0]       burst_len_i,
  output rsa_pkg::rsa_state_t                  state_o,
  output rsa_pkg::rsa_result_t                 result_o
);
  import rsa_pkg::*;

  logic [ScaledWidth-1:0]   hold_scaled;
  logic [DeadlineWidth-1:0] deadline;
  logic                     ord_live;
  logic                     hd_live;
  rsa_src_e                 chosen;
  logic                     switched;
  logic                     emit_stop;
  logic [BurstWidth-1:0]    stops_mid;
  logic [EvCount-1:0]       bump;

  // Deadline for updates: now plus hold in microseconds
  assign hold_scaled = ScaledWidth'(item_i.hold_ms) * ScaledWidth'(UsPerMs);
  assign deadline    = DeadlineWidth'(item_i.now_us) + DeadlineWidth'(hold_scaled);

  // Expiry needs now strictly past the deadline
  assign ord_live = state_i.ord_on &&
                    !(DeadlineWidth'(item_i.now_us) > state_i.ord_deadline);
  assign hd_live  = state_i.hd_on &&
                    !(DeadlineWidth'(item_i.now_us) > state_i.hd_deadline);

  // Selection and stop burst for ticks
  always_comb begin
    if (state_i.mode == ModeCompat) begin
      chosen = ord_live ? SrcOrd : SrcNone;
    end else begin
      chosen = hd_live ? SrcHd : SrcNone;
    end
    switched = (chosen != state_i.sel);
    if (switched) begin
      stops_mid = (chosen == SrcNone) ? burst_len_i : '0;
    end else begin
      stops_mid = state_i.stops_left;
    end
    emit_stop = (chosen == SrcNone) && (stops_mid != '0);
  end

  // Apply the command
  always_comb begin
    state_o = state_i;
    bump    = '0;
    result_o.chosen    = state_i.sel;
    result_o.earlier   = state_i.sel;
    result_o.switched  = 1'b0;
    result_o.emit_stop = 1'b0;
    case (item_i.cmd)
      CmdSetMode: begin
        bump[EvCompat] = item_i.mode_req;
        bump[EvHaptic] = !item_i.mode_req;
        if (state_i.mode != rsa_mode_e'(item_i.mode_req)) begin
          state_o.mode     = rsa_mode_e'(item_i.mode_req);
          bump[EvModeChg]  = 1'b1;
        end
      end
      CmdUpdOrd: begin
        state_o.ord_on       = item_i.src_active;
        state_o.ord_deadline = item_i.src_active ? deadline : '0;
      end
      CmdUpdHd: begin
        state_o.hd_on       = item_i.src_active;
        state_o.hd_deadline = item_i.src_active ? deadline : '0;
        bump[EvBlocked]     = item_i.src_active && (state_i.mode == ModeCompat);
      end
      CmdTick: begin
        state_o.ord_on       = ord_live;
        state_o.ord_deadline = ord_live ? state_i.ord_deadline : '0;
        state_o.hd_on        = hd_live;
        state_o.hd_deadline  = hd_live ? state_i.hd_deadline : '0;
        state_o.sel          = chosen;
        state_o.stops_left   = emit_stop ? stops_mid - 1'b1 : stops_mid;
        bump[EvSwitch]       = switched;
        bump[EvPreempt]      = (chosen == SrcHd) && (state_i.sel == SrcOrd);
        bump[EvFallback]     = (chosen == SrcOrd) && (state_i.sel == SrcHd);
        result_o.chosen      = chosen;
        result_o.switched    = switched;
        result_o.emit_stop   = emit_stop;
      end
      default: begin
        state_o = state_i;
      end
    endcase

    // Advance wrapping event counters
    for (int i = 0; i < EvCount; i++) begin
      state_o.counters[i] = state_i.counters[i] + CntWidth'(bump[i]);
      result_o.counters[i] = state_o.counters[i][OutCntWidth-1:0];
    end
    result_o.mode = state_o.mode;
  end

endmodule

FILE: rtl/rumble_source_arbiter_core.sv
// Rumble source arbiter: one result beat per command beat, held in a registered output.
// One beat per cycle while the skid entry is empty; register plus skid decouple stalls.
// State updates at the accepting edge, where the result enters the output or skid register.
// Reset (async, active low) clears mode, sources, selection, stop count, counters,
// output valids, and sets the stop burst length to 3. Depends on rsa_pkg, rsa_step.
`timescale 1ns / 1ps

module rumble_source_arbiter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // mode_request, source_active, time_now_us, hold_time_ms
  input  logic [1:0]   s_axis_tuser,   // command
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [231:0] m_axis_tdata,   // chosen_source, earlier_source, source_switched,
                                       // emit_stop, current_mode, switch_count,
                                       // preempt_count, fallback_count, blocked_hd_count,
                                       // mode_change_count, compat_request_count,
                                       // haptic_request_count, zero pad
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rsa_pkg::*;

  rsa_item_t             item;
  rsa_state_t            state_q, state_d;
  rsa_result_t           result;
  rsa_result_t           out_q, out_d;
  rsa_result_t           skid_q, skid_d;
  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  logic [BurstWidth-1:0] burst_q;
  logic                  accept;
  logic                  take;

  // Unpack the command beat
  assign item.cmd        = rsa_cmd_e'(s_axis_tuser);
  assign item.mode_req   = s_axis_tdata[0];
  assign item.src_active = s_axis_tdata[1];
  assign item.now_us     = s_axis_tdata[63:2];
  assign item.hold_ms    = s_axis_tdata[95:64];

  rsa_step u_step (
    .item_i      (item),
    .state_i     (state_q),
    .burst_len_i (burst_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid_q && m_axis_tready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrStopBurst) ? 32'(burst_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= BurstReset;
    end else if (psel && penable && pwrite && (paddr == AddrStopBurst)) begin
      burst_q <= pwdata[BurstWidth-1:0];
    end
  end

  // Arbiter state advances on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register with skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = accept;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Pack the result beat
  assign m_axis_tvalid = out_valid_q;
  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[1:0]   = out_q.chosen;
    m_axis_tdata[3:2]   = out_q.earlier;
    m_axis_tdata[4]     = out_q.switched;
    m_axis_tdata[5]     = out_q.emit_stop;
    m_axis_tdata[6]     = out_q.mode;
    m_axis_tdata[38:7]    = out_q.counters[EvSwitch];
    m_axis_tdata[70:39]   = out_q.counters[EvPreempt];
    m_axis_tdata[102:71]  = out_q.counters[EvFallback];
    m_axis_tdata[134:103] = out_q.counters[EvBlocked];
    m_axis_tdata[166:135] = out_q.counters[EvModeChg];
    m_axis_tdata[198:167] = out_q.counters[EvCompat];
    m_axis_tdata[230:199] = out_q.counters[EvHaptic];
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for rumble_source_arbiter_core: drives command beats and
// register writes, predicts each result beat and compares it field by field.
// Depends on rsa_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import rsa_pkg::*;

  // Register index four: writes there must leave the stop burst length alone
  localparam logic [2:0] AddrUnused = 3'd4;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // mode_request, source_active, time_now_us, hold_time_ms
  logic [1:0]   s_axis_tuser = '0;   // command
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [231:0] m_axis_tdata;        // chosen, earlier, switched, emit_stop, mode,
                                     // seven 32-bit counters, zero pad
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  rumble_source_arbiter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Command beats waiting to go out and results waiting to come back
  rsa_item_t   cmd_pending[$];
  rsa_result_t outcome_expected[$];
  int          cmds_queued = 0;
  int          cmds_taken = 0;
  int          mismatches = 0;
  logic        cmd_taken = 1'b0;
  logic        calm = 1'b0;       // no idling on either side

  // Predicted arbiter state
  logic [7:0]                       burst_len;
  rsa_mode_e                        pred_mode;
  logic                             ord_on, hd_on;
  logic [DeadlineWidth-1:0]         ord_dl, hd_dl;
  rsa_src_e                         sel;
  logic [7:0]                       stops;
  logic [EvCount-1:0][CntWidth-1:0] events;

  // Stimulus generator bookkeeping
  logic [61:0] gen_clock;
  logic [62:0] gen_ord_dl, gen_hd_dl;

  string cnt_names[EvCount] = '{"switch_count", "preempt_count", "fallback_count",
                                "blocked_hd_count", "mode_change_count",
                                "compat_request_count", "haptic_request_count"};

  task automatic clear_arbiter();
    burst_len = BurstReset;
    pred_mode = ModeHaptic;
    ord_on = 1'b0;
    hd_on = 1'b0;
    ord_dl = '0;
    hd_dl = '0;
    sel = SrcNone;
    stops = '0;
    events = '0;
  endtask

  // Advance the predicted state by one command and return its result
  task automatic arbitrate(input rsa_item_t it, output rsa_result_t r);
    logic [DeadlineWidth-1:0] dl;
    rsa_src_e prev, pick;
    logic flip, stop;
    dl = {1'b0, it.now_us} + DeadlineWidth'(it.hold_ms) * DeadlineWidth'(UsPerMs);
    prev = sel;
    pick = sel;
    flip = 1'b0;
    stop = 1'b0;
    case (it.cmd)
      CmdSetMode: begin
        if (it.mode_req) events[EvCompat] += 32'd1;
        else events[EvHaptic] += 32'd1;
        if (pred_mode != rsa_mode_e'(it.mode_req)) begin
          pred_mode = rsa_mode_e'(it.mode_req);
          events[EvModeChg] += 32'd1;
        end
      end
      CmdUpdOrd: begin
        ord_on = it.src_active;
        ord_dl = it.src_active ? dl : '0;
      end
      CmdUpdHd: begin
        hd_on = it.src_active;
        hd_dl = it.src_active ? dl : '0;
        if (it.src_active && pred_mode == ModeCompat) events[EvBlocked] += 32'd1;
      end
      default: begin
        // expire first, strictly past the deadline only
        if (hd_on && {1'b0, it.now_us} > hd_dl) begin
          hd_on = 1'b0;
          hd_dl = '0;
        end
        if (ord_on && {1'b0, it.now_us} > ord_dl) begin
          ord_on = 1'b0;
          ord_dl = '0;
        end
        if (pred_mode == ModeCompat) pick = ord_on ? SrcOrd : SrcNone;
        else pick = hd_on ? SrcHd : SrcNone;
        if (pick != prev) begin
          flip = 1'b1;
          events[EvSwitch] += 32'd1;
          if (pick == SrcHd && prev == SrcOrd) events[EvPreempt] += 32'd1;
          else if (pick == SrcOrd && prev == SrcHd) events[EvFallback] += 32'd1;
          // arm the stop burst on a drop to none, discard it otherwise
          stops = (pick == SrcNone && prev != SrcNone) ? burst_len : 8'd0;
          sel = pick;
        end
        if (pick == SrcNone && stops != 0) begin
          stops -= 8'd1;
          stop = 1'b1;
        end
      end
    endcase
    r.chosen = pick;
    r.earlier = prev;
    r.switched = flip;
    r.emit_stop = stop;
    r.mode = pred_mode;
    r.counters = events;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sample both streams and the register port at the rising edge
  always @(posedge clk_i) begin
    rsa_result_t want;
    rsa_item_t   it;
    if (rst_ni) begin
      cmd_taken = s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_expected.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          want = outcome_expected.pop_front();
          check_field("chosen_source", 32'(want.chosen), 32'(m_axis_tdata[1:0]));
          check_field("earlier_source", 32'(want.earlier), 32'(m_axis_tdata[3:2]));
          check_field("source_switched", 32'(want.switched), 32'(m_axis_tdata[4]));
          check_field("emit_stop", 32'(want.emit_stop), 32'(m_axis_tdata[5]));
          check_field("current_mode", 32'(want.mode), 32'(m_axis_tdata[6]));
          for (int k = 0; k < EvCount; k++)
            check_field(cnt_names[k], want.counters[k], m_axis_tdata[7 + 32*k +: 32]);
        end
      end
      if (psel && penable && pwrite && pready && paddr == AddrStopBurst)
        burst_len = pwdata[7:0];
      if (cmd_taken) begin
        it.cmd = rsa_cmd_e'(s_axis_tuser);
        it.mode_req = s_axis_tdata[0];
        it.src_active = s_axis_tdata[1];
        it.now_us = s_axis_tdata[63:2];
        it.hold_ms = s_axis_tdata[95:64];
        arbitrate(it, want);
        outcome_expected.push_back(want);
        cmds_taken++;
      end
    end
  end

  // Command driver: hold the beat until taken, idle in random bursts
  int src_gap = 0;
  always @(negedge clk_i) begin
    rsa_item_t it;
    logic      vld;
    if (rst_ni && (!s_axis_tvalid || cmd_taken)) begin
      vld = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 11);
      end else if (cmd_pending.size() > 0) begin
        it = cmd_pending.pop_front();
        s_axis_tdata <= {it.hold_ms, it.now_us, it.src_active, it.mode_req};
        s_axis_tuser <= it.cmd;
        vld = 1'b1;
      end
      s_axis_tvalid <= vld;
    end
  end

  // Result sink: stall in random bursts
  int sink_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_cmd(input rsa_cmd_e cmd, input logic req, input logic act,
                         input logic [61:0] now, input logic [31:0] hold);
    rsa_item_t it;
    it.cmd = cmd;
    it.mode_req = req;
    it.src_active = act;
    it.now_us = now;
    it.hold_ms = hold;
    cmd_pending.push_back(it);
    cmds_queued++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic verify_burst();
    logic [31:0] rd;
    apb_access(1'b0, AddrStopBurst, '0, rd);
    check_field("stop_burst_length", 32'(burst_len), 32'(rd[7:0]));
  endtask

  task automatic program_burst(input logic [7:0] len);
    logic [31:0] rd;
    apb_access(1'b1, AddrStopBurst, {24'($urandom_range(0, 32'hFF_FFFF)), len}, rd);
    verify_burst();
  endtask

  // Wait until every command has been taken and answered
  task automatic drain();
    while (cmds_taken != cmds_queued || outcome_expected.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [61:0] rand_time();
    return 62'({$urandom, $urandom});
  endfunction

  // Mostly coherent sessions around a running clock, some raw noise
  task automatic gen_session(input int n);
    int          pick;
    logic [61:0] t;
    logic [31:0] hold;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        gen_clock = rand_time();
        if (&gen_clock[61:32]) gen_clock[61:32] -= 1;
      end
      hold = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_cmd(rsa_cmd_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), rand_time(), $urandom);
      end else if (pick < 17) begin
        add_cmd(CmdSetMode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                gen_clock, $urandom);
      end else if (pick < 37) begin
        add_cmd(CmdUpdOrd, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                gen_clock, hold);
        gen_ord_dl = {1'b0, gen_clock} + 63'(hold) * 63'd1000;
      end else if (pick < 57) begin
        add_cmd(CmdUpdHd, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                gen_clock, hold);
        gen_hd_dl = {1'b0, gen_clock} + 63'(hold) * 63'd1000;
      end else begin
        // land ticks on or just past a deadline now and then
        pick = $urandom_range(0, 9);
        t = gen_clock + 62'($urandom_range(0, 1500));
        if (pick == 0 && !gen_hd_dl[62] && gen_hd_dl[61:0] >= gen_clock) t = gen_hd_dl[61:0];
        if (pick == 1 && !gen_ord_dl[62] && gen_ord_dl[61:0] >= gen_clock) t = gen_ord_dl[61:0];
        if (pick == 2 && !gen_hd_dl[62] && gen_hd_dl[61:0] >= gen_clock && !(&gen_hd_dl[61:0]))
          t = gen_hd_dl[61:0] + 1;
        if (pick == 3 && !gen_ord_dl[62] && gen_ord_dl[61:0] >= gen_clock && !(&gen_ord_dl[61:0]))
          t = gen_ord_dl[61:0] + 1;
        if (t > gen_clock) gen_clock = t;
        add_cmd(CmdTick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t, $urandom);
      end
    end
  endtask

  initial begin
    logic [61:0] tmax;
    logic [31:0] rd;
    logic [7:0]  lens[6];
    tmax = '1;
    clear_arbiter();
    gen_clock = '0;
    gen_ord_dl = '0;
    gen_hd_dl = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    verify_burst();

    // Directed walk with the reset burst length of three
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd0,    32'd0);
    add_cmd(CmdSetMode, 1'b0, 1'b1, 62'd50,   32'd9);
    add_cmd(CmdUpdHd,   1'b1, 1'b1, 62'd100,  32'd2);   // deadline 2100
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd2100, 32'd0);   // deadline equal to now
    add_cmd(CmdUpdOrd,  1'b0, 1'b1, 62'd2100, 32'd5);   // deadline 7100
    add_cmd(CmdSetMode, 1'b1, 1'b0, 62'd2150, 32'd0);
    add_cmd(CmdUpdHd,   1'b0, 1'b1, 62'd2200, 32'd10);  // blocked in compat mode
    add_cmd(CmdTick,    1'b1, 1'b1, 62'd2300, 32'd0);   // hd to ordinary
    add_cmd(CmdSetMode, 1'b0, 1'b0, 62'd2310, 32'd0);
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd2320, 32'd0);   // ordinary to hd
    add_cmd(CmdUpdHd,   1'b1, 1'b0, 62'd2400, 32'd7);   // inactive clears deadline
    for (int i = 0; i < 4; i++)
      add_cmd(CmdTick, 1'b0, 1'b0, 62'd2410 + 62'(i), 32'd0);  // drop, then spend stops
    add_cmd(CmdSetMode, 1'b1, 1'b1, 62'd2500, 32'd0);
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd2500, 32'd0);   // none to ordinary
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd7101, 32'd0);   // ordinary expires
    add_cmd(CmdUpdOrd,  1'b0, 1'b1, 62'd7200, 32'd1);
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd7300, 32'd0);   // reselect drops pending stops
    add_cmd(CmdTick,    1'b0, 1'b0, 62'd7301, 32'd0);
    add_cmd(CmdUpdHd,   1'b1, 1'b1, tmax,     32'hFFFF_FFFF);
    add_cmd(CmdUpdOrd,  1'b1, 1'b1, tmax,     32'hFFFF_FFFF);
    add_cmd(CmdTick,    1'b1, 1'b1, tmax,     32'hFFFF_FFFF);
    add_cmd(CmdUpdOrd,  1'b1, 1'b0, 62'd0,    32'd0);
    add_cmd(CmdTick,    1'b1, 1'b1, tmax,     32'hFFFF_FFFF);
    drain();

    // Random sessions, one burst length each, extremes included
    lens = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd2,
             8'($urandom_range(0, 255))};
    for (int p = 0; p < 6; p++) begin
      program_burst(lens[p]);
      if (p == 2) begin
        apb_access(1'b1, AddrUnused, $urandom, rd);
        verify_burst();
      end
      if (p == 5) calm = 1'b1;
      gen_session(72);
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
